[src/ntq_pkg.sv]
// Shared types and constants for the note timing quantizer.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package ntq_pkg;

    localparam int GRID_W  = 27;          // widest grid length: 3/2 * 4 * 65535 * 255
    localparam int SWADJ_W = GRID_W + 1;  // signed swing offset in ticks
    localparam int STR_W   = 16;
    localparam int DEN_W   = 8;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 16;

    localparam logic [CFG_AW-1:0] REG_TPQ      = 3'd0;
    localparam logic [CFG_AW-1:0] REG_NUM      = 3'd1;
    localparam logic [CFG_AW-1:0] REG_DEN      = 3'd2;
    localparam logic [CFG_AW-1:0] REG_MOD      = 3'd3;
    localparam logic [CFG_AW-1:0] REG_STRENGTH = 3'd4;
    localparam logic [CFG_AW-1:0] REG_SWING    = 3'd5;

    localparam logic [1:0] MOD_PLAIN   = 2'd0;
    localparam logic [1:0] MOD_TRIPLET = 2'd1;
    localparam logic [1:0] MOD_DOTTED  = 2'd2;

    localparam logic [STR_W-1:0]  Q15_ONE     = 16'd32768;
    localparam logic signed [15:0] SWING_LIMIT = 16'sd29491;

    typedef struct packed {
        logic                      ok;
        logic [GRID_W-1:0]         grid;
        logic signed [SWADJ_W-1:0] swing_adj;
        logic [STR_W-1:0]          strength;
    } t_cfg;

endpackage
`default_nettype wire

[src/note_timing_quantizer.sv]
// Note timing quantizer: top level joining configuration, divider and output stages.
// Depends on ntq_pkg, ntq_cfg, ntq_div and ntq_post.
//
// Snaps note events to the nearest slot of a grid of 4*ppq*num/den ticks (times 2/3
// for triplets, 3/2 for dotted), shifts odd slots by the swing and pulls the tick
// toward that target by the strength; non-note events pass unchanged, and a grid
// of zero length passes every event unchanged with o_status set. The datapath is
// fully pipelined: one transaction per cycle in steady state while the output is
// not stalled, through a one-bit-per-stage divider that finds the nearest slot and
// the four stages after it. Stages hold their data under backpressure and bubbles
// close up, so the input keeps taking transactions while a result waits at the
// output. After any configuration write, the grid length is recomputed by a serial
// divider and o_ready stays low meanwhile; a zero denominator sets a zero grid
// without dividing. Reset presets the grid to 120 ticks, the default setting.
// Write configuration only while no transaction is in flight.
`default_nettype none
module note_timing_quantizer #(
    parameter int TICK_BITS = 40
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [ntq_pkg::CFG_AW-1:0] i_cfg_addr,
    input  wire logic [ntq_pkg::CFG_DW-1:0] i_cfg_wdata,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [TICK_BITS-1:0]       i_event_tick,
    input  wire logic                       i_is_note,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [TICK_BITS-1:0]            o_new_tick,
    output logic                            o_status
);
    ntq_pkg::t_cfg                w_cfg;
    logic                         w_div_ready;
    logic                         w_div_valid;
    logic [ntq_pkg::GRID_W-1:0]   w_rem;
    logic                         w_q0;
    logic [TICK_BITS-1:0]         w_tick;
    logic                         w_note;
    logic                         w_post_ready;

    ntq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // hold the input off while the grid length is being recomputed
    assign o_ready = w_div_ready && w_cfg.ok;

    ntq_div #(.TB(TICK_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid && w_cfg.ok),
        .o_ready (w_div_ready),
        .i_tick  (i_event_tick),
        .i_note  (i_is_note),
        .i_grid  (w_cfg.grid),
        .o_valid (w_div_valid),
        .i_ready (w_post_ready),
        .o_rem   (w_rem),
        .o_q0    (w_q0),
        .o_tick  (w_tick),
        .o_note  (w_note)
    );

    ntq_post #(.TB(TICK_BITS)) u_post (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_div_valid),
        .o_ready    (w_post_ready),
        .i_rem      (w_rem),
        .i_q0       (w_q0),
        .i_tick     (w_tick),
        .i_note     (w_note),
        .i_cfg      (w_cfg),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_new_tick (o_new_tick),
        .o_status   (o_status)
    );

endmodule
`default_nettype wire

[src/ntq_cfg.sv]
// Configuration registers, serial grid-length divider and derived swing offset.
// Depends on ntq_pkg.
`default_nettype none
module ntq_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [ntq_pkg::CFG_AW-1:0] i_cfg_addr,
    input  wire logic [ntq_pkg::CFG_DW-1:0] i_cfg_wdata,
    output ntq_pkg::t_cfg                   o_cfg
);
    localparam int GW = ntq_pkg::GRID_W;
    localparam int DW = ntq_pkg::DEN_W;
    localparam int CW = $clog2(GW + 1);
    localparam logic [GW-1:0] RESET_GRID = 27'd120;
    // floor(x / 3) = (x * THIRD_RECIP) >> 33 for every x below 2^32
    localparam logic [31:0]   THIRD_RECIP = 32'hAAAA_AAAB;

    typedef enum logic [3:0] {
        GS_IDLE = 4'b0001,
        GS_LOAD = 4'b0010,
        GS_DIV  = 4'b0100,
        GS_TRI  = 4'b1000
    } t_gstate;

    logic [15:0]        r_tpq;
    logic [7:0]         r_num;
    logic [7:0]         r_den;
    logic [1:0]         r_mod;
    logic [15:0]        r_str;
    logic signed [15:0] r_swing;

    t_gstate        r_state;
    logic           r_ok;
    logic [CW-1:0]  r_cnt;
    logic [GW-1:0]  r_grid;
    logic [GW-1:0]  r_quo;
    logic [DW-1:0]  r_rem;
    logic [DW-1:0]  r_dvs;

    logic [DW:0]    w_trial;
    logic           w_ge;
    logic [DW-1:0]  n_rem;
    logic [GW-1:0]  n_quo;
    logic [GW-1:0]  w_dividend;
    logic [GW:0]    w_dot;
    logic [GW+31:0] w_tri_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpq   <= 16'd480;
            r_num   <= 8'd1;
            r_den   <= 8'd16;
            r_mod   <= ntq_pkg::MOD_PLAIN;
            r_str   <= ntq_pkg::Q15_ONE;
            r_swing <= 16'sd0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ntq_pkg::REG_TPQ:      r_tpq   <= i_cfg_wdata;
                ntq_pkg::REG_NUM:      r_num   <= i_cfg_wdata[7:0];
                ntq_pkg::REG_DEN:      r_den   <= i_cfg_wdata[7:0];
                ntq_pkg::REG_MOD:      r_mod   <= i_cfg_wdata[1:0];
                ntq_pkg::REG_STRENGTH: r_str   <= i_cfg_wdata;
                ntq_pkg::REG_SWING:    r_swing <= $signed(i_cfg_wdata);
                default: begin
                end
            endcase
        end
    end

    // restoring division, one quotient bit per cycle
    assign w_trial    = {r_rem, r_quo[GW-1]};
    assign w_ge       = (w_trial >= {1'b0, r_dvs});
    assign n_rem      = w_ge ? DW'(w_trial - {1'b0, r_dvs}) : w_trial[DW-1:0];
    assign n_quo      = {r_quo[GW-2:0], w_ge};
    assign w_dividend = GW'({r_tpq, 2'b00}) * GW'(r_num);
    assign w_dot      = {1'b0, n_quo} + {n_quo, 1'b0};
    assign w_tri_prod = {32'd0, r_quo} * {{GW{1'b0}}, THIRD_RECIP};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= GS_IDLE;
            r_ok    <= 1'b1;
            r_grid  <= RESET_GRID;
            r_cnt   <= '0;
        end else if (i_cfg_we) begin
            r_state <= GS_LOAD;
            r_ok    <= 1'b0;
        end else begin
            case (r_state)
                GS_LOAD: begin
                    if (r_den == '0) begin
                        r_grid  <= '0;
                        r_ok    <= 1'b1;
                        r_state <= GS_IDLE;
                    end else begin
                        r_quo   <= w_dividend;
                        r_rem   <= '0;
                        r_dvs   <= r_den;
                        r_cnt   <= CW'(GW);
                        r_state <= GS_DIV;
                    end
                end
                GS_DIV: begin
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt != CW'(1)) begin
                        r_quo <= n_quo;
                    end else if (r_mod == ntq_pkg::MOD_TRIPLET) begin
                        // hold twice the grid, take a third of it next cycle
                        r_quo   <= {n_quo[GW-2:0], 1'b0};
                        r_state <= GS_TRI;
                    end else begin
                        r_quo <= n_quo;
                        if (r_mod == ntq_pkg::MOD_DOTTED) begin
                            r_grid <= w_dot[GW:1];
                        end else begin
                            r_grid <= n_quo;
                        end
                        r_ok    <= 1'b1;
                        r_state <= GS_IDLE;
                    end
                end
                GS_TRI: begin
                    r_grid  <= {1'b0, w_tri_prod[GW+31:33]};
                    r_ok    <= 1'b1;
                    r_state <= GS_IDLE;
                end
                default: r_state <= GS_IDLE;
            endcase
        end
    end

    // swing offset in ticks: round(swing * grid / 32768), swing clamped to +-29491, two registers deep
    logic signed [15:0] w_sw_sat;
    logic signed [43:0] r_sw_prod;
    logic [43:0]        w_sw_mag;
    logic [43:0]        w_sw_rnd;
    logic signed [ntq_pkg::SWADJ_W-1:0] r_swing_adj;
    logic [ntq_pkg::STR_W-1:0]          w_str_sat;

    always_comb begin
        if (r_swing > ntq_pkg::SWING_LIMIT) begin
            w_sw_sat = ntq_pkg::SWING_LIMIT;
        end else if (r_swing < -ntq_pkg::SWING_LIMIT) begin
            w_sw_sat = -ntq_pkg::SWING_LIMIT;
        end else begin
            w_sw_sat = r_swing;
        end
    end

    assign w_sw_mag = r_sw_prod[43] ? 44'(-r_sw_prod) : 44'(r_sw_prod);
    assign w_sw_rnd = (w_sw_mag + 44'd16384) >> 15;

    always_ff @(posedge i_clk) begin
        r_sw_prod   <= 44'(w_sw_sat) * $signed({17'd0, r_grid});
        r_swing_adj <= r_sw_prod[43] ? -$signed(w_sw_rnd[ntq_pkg::SWADJ_W-1:0])
                                     : $signed(w_sw_rnd[ntq_pkg::SWADJ_W-1:0]);
    end

    assign w_str_sat = (r_str > ntq_pkg::Q15_ONE) ? ntq_pkg::Q15_ONE : r_str;
    assign o_cfg     = {r_ok, r_grid, r_swing_adj, w_str_sat};

endmodule
`default_nettype wire

[src/ntq_div.sv]
// Pipelined restoring divider: (tick + grid/2) by grid, one quotient bit per stage.
// Depends on ntq_pkg.
`default_nettype none
module ntq_div #(
    parameter int TB = 40
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [TB-1:0]              i_tick,
    input  wire logic                       i_note,
    input  wire logic [ntq_pkg::GRID_W-1:0] i_grid,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [ntq_pkg::GRID_W-1:0]      o_rem,
    output logic                            o_q0,
    output logic [TB-1:0]                   o_tick,
    output logic                            o_note
);
    localparam int GW = ntq_pkg::GRID_W;
    localparam int NW = ((TB > GW) ? TB : GW) + 1;

    logic          r_v    [0:NW];
    logic [GW-1:0] r_rem  [0:NW];
    logic [NW-1:0] r_num  [0:NW];
    logic          r_q0   [0:NW];
    logic [TB-1:0] r_tick [0:NW];
    logic          r_note [0:NW];
    logic          w_rdy  [0:NW+1];

    assign w_rdy[NW+1] = i_ready;

    // entry stage: add half a grid so truncation rounds to nearest
    assign w_rdy[0] = !r_v[0] || w_rdy[1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_rdy[0]) begin
            r_v[0] <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_num[0]  <= NW'(i_tick) + NW'(i_grid[GW-1:1]);
            r_rem[0]  <= '0;
            r_q0[0]   <= 1'b0;
            r_tick[0] <= i_tick;
            r_note[0] <= i_note;
        end
    end

    for (genvar k = 1; k <= NW; k++) begin : g_stage
        logic [GW:0]   w_trial;
        logic          w_ge;
        assign w_trial  = {r_rem[k-1], r_num[k-1][NW-1]};
        assign w_ge     = (w_trial >= {1'b0, i_grid});
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= r_v[k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_rdy[k] && r_v[k-1]) begin
                r_rem[k]  <= w_ge ? GW'(w_trial - {1'b0, i_grid}) : w_trial[GW-1:0];
                r_num[k]  <= {r_num[k-1][NW-2:0], 1'b0};
                r_q0[k]   <= w_ge;
                r_tick[k] <= r_tick[k-1];
                r_note[k] <= r_note[k-1];
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NW];
    assign o_rem   = r_rem[NW];
    assign o_q0    = r_q0[NW];
    assign o_tick  = r_tick[NW];
    assign o_note  = r_note[NW];

endmodule
`default_nettype wire

[src/ntq_post.sv]
// Offset and swing, strength multiply and rounding stages, then clamp into the output register.
// Depends on ntq_pkg.
`default_nettype none
module ntq_post #(
    parameter int TB = 40
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [ntq_pkg::GRID_W-1:0] i_rem,
    input  wire logic                       i_q0,
    input  wire logic [TB-1:0]              i_tick,
    input  wire logic                       i_note,
    input  wire ntq_pkg::t_cfg              i_cfg,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [TB-1:0]                   o_new_tick,
    output logic                            o_status
);
    localparam int GW = ntq_pkg::GRID_W;
    localparam int DW = GW + 2;
    localparam int PW = ntq_pkg::STR_W + 1 + DW;
    localparam int MW = PW - 15;
    localparam int XW = ((TB > MW) ? TB : MW) + 1;
    localparam logic [XW-1:0] TICK_MAX = XW'({TB{1'b1}});

    logic w_rdy0, w_rdy1, w_rdy2, w_rdy3;
    logic r_v0, r_v1, r_v2, r_v3;

    logic signed [DW-1:0] r_d;
    logic signed [PW-1:0] r_prod;
    logic                 r_neg;
    logic [MW-1:0]        r_mag;
    logic [TB-1:0]        r_t0, r_t1, r_t2;
    logic                 r_snap0, r_snap1, r_snap2;
    logic                 r_err0, r_err1, r_err2;
    logic [TB-1:0]        r_out_tick;
    logic                 r_out_status;

    logic                 w_err;
    logic signed [DW-1:0] w_d;
    logic [PW-1:0]        w_mag;
    logic [PW-1:0]        w_rnd;
    logic [XW-1:0]        w_sub;
    logic [XW-1:0]        w_add;
    logic [TB-1:0]        w_res;

    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign w_rdy0  = !r_v0 || w_rdy1;
    assign o_ready = w_rdy0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy0) r_v0 <= i_valid;
            if (w_rdy1) r_v1 <= r_v0;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    // offset to nearest slot is grid/2 - remainder; odd slots take the swing
    assign w_err = (i_cfg.grid == '0);
    assign w_d   = $signed({2'b00, i_cfg.grid[GW-1:1]}) - $signed({2'b00, i_rem})
                 + (i_q0 ? DW'(i_cfg.swing_adj) : DW'(0));

    always_ff @(posedge i_clk) begin
        if (w_rdy0 && i_valid) begin
            r_d     <= w_d;
            r_t0    <= i_tick;
            r_snap0 <= i_note && !w_err;
            r_err0  <= w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && r_v0) begin
            r_prod  <= $signed({1'b0, i_cfg.strength}) * r_d;
            r_t1    <= r_t0;
            r_snap1 <= r_snap0;
            r_err1  <= r_err0;
        end
    end

    // round half away from zero on the magnitude
    assign w_mag = r_prod[PW-1] ? PW'(-r_prod) : PW'(r_prod);
    assign w_rnd = (w_mag + PW'(16384)) >> 15;

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r_neg   <= r_prod[PW-1];
            r_mag   <= w_rnd[MW-1:0];
            r_t2    <= r_t1;
            r_snap2 <= r_snap1;
            r_err2  <= r_err1;
        end
    end

    // clamp at zero below and at the tick range above
    assign w_sub = XW'(r_t2) - XW'(r_mag);
    assign w_add = XW'(r_t2) + XW'(r_mag);

    always_comb begin
        if (!r_snap2) begin
            w_res = r_t2;
        end else if (r_neg) begin
            w_res = w_sub[XW-1] ? '0 : w_sub[TB-1:0];
        end else begin
            w_res = (w_add > TICK_MAX) ? TICK_MAX[TB-1:0] : w_add[TB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_v2) begin
            r_out_tick   <= w_res;
            r_out_status <= r_err2;
        end
    end

    assign o_valid    = r_v3;
    assign o_new_tick = r_out_tick;
    assign o_status   = r_out_status;

endmodule
`default_nettype wire
